### sv/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_W  = 8;
    localparam int TAG_W  = 16;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int STAT_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_in_req;

    typedef struct packed {
        logic              served_valid;
        logic [KEY_W-1:0]  served_key;
        logic [TAG_W-1:0]  served_tag;
        logic              head_valid;
        logic [KEY_W-1:0]  head_key;
        logic [TAG_W-1:0]  head_tag;
        logic [FILL_W-1:0] fill_count;
        logic [STAT_W-1:0] status;
    } t_out_req;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### sv/ssq_cell.sv
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: holds a key and tag, shifts toward the tail
// on insert and toward the head on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_cell (
    input  wire                              i_clk,
    input  wire ssq_pkg::t_cell_ctrl         i_ctrl,
    input  wire                              i_occupied,
    input  wire                              i_prev_after,
    input  wire [ssq_pkg::KEY_W-1:0]         i_prev_key,
    input  wire [ssq_pkg::TAG_W-1:0]         i_prev_tag,
    input  wire [ssq_pkg::KEY_W-1:0]         i_next_key,
    input  wire [ssq_pkg::TAG_W-1:0]         i_next_tag,
    output logic                             o_after,
    output logic [ssq_pkg::KEY_W-1:0]        o_key,
    output logic [ssq_pkg::TAG_W-1:0]        o_tag
);

    logic [ssq_pkg::KEY_W-1:0] r_key;
    logic [ssq_pkg::TAG_W-1:0] r_tag;

    // slot lies behind the insertion point: empty or strictly larger key
    assign o_after = !i_occupied || (r_key > i_ctrl.key);
    assign o_key   = r_key;
    assign o_tag   = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && o_after) begin
            if (i_prev_after) begin
                r_key <= i_prev_key;
                r_tag <= i_prev_tag;
            end else begin
                r_key <= i_ctrl.key;
                r_tag <= i_ctrl.tag;
            end
        end else if (i_ctrl.rem) begin
            r_key <= i_next_key;
            r_tag <= i_next_tag;
        end
    end

endmodule

`default_nettype wire

### sv/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept sorted in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each request is either an insert of (key, tag) or a remove of the head
// entry, and produces exactly one result, registered in the cycle after it
// is accepted. Every cell compares its key with the new key at once, so an
// insert or a remove updates all cells together and a new request can be
// accepted in every cycle; the only limit is the result register, which holds
// the input stalled while its result is stalled. Equal keys leave in arrival
// order. Insert on a full queue and remove on an empty queue leave the queue
// as it is and report their status. Head fields show the entry now in the
// first cell, zero when the queue is empty.
`default_nettype none

module stable_sorted_priority_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire ssq_pkg::t_in_req i_in_req,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ssq_pkg::t_out_req   o_out_req
);

    localparam int QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;

    logic                       r_served_valid;
    logic [ssq_pkg::KEY_W-1:0]  r_served_key;
    logic [ssq_pkg::TAG_W-1:0]  r_served_tag;
    logic [ssq_pkg::STAT_W-1:0] r_status;
    logic [ssq_pkg::STAT_W-1:0] n_status;

    logic accept;
    logic empty;
    logic full;
    ssq_pkg::t_cell_ctrl ctrl;

    logic                      after [QUEUE_DEPTH];
    logic [ssq_pkg::KEY_W-1:0] ckey  [QUEUE_DEPTH];
    logic [ssq_pkg::TAG_W-1:0] ctag  [QUEUE_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign empty      = (r_count == '0);
    assign full       = (r_count == DEPTH_C);

    always_comb begin
        ctrl.ins = accept && (i_in_req.operation == ssq_pkg::OP_INSERT) && !full;
        ctrl.rem = accept && (i_in_req.operation == ssq_pkg::OP_REMOVE) && !empty;
        ctrl.key = i_in_req.key;
        ctrl.tag = i_in_req.tag;
    end

    always_comb begin
        n_count  = r_count;
        n_status = ssq_pkg::ST_OK;
        if (i_in_req.operation == ssq_pkg::OP_INSERT) begin
            if (full) begin
                n_status = ssq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = ssq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        logic                      prev_after;
        logic [ssq_pkg::KEY_W-1:0] prev_key;
        logic [ssq_pkg::TAG_W-1:0] prev_tag;
        logic [ssq_pkg::KEY_W-1:0] next_key;
        logic [ssq_pkg::TAG_W-1:0] next_tag;

        if (g == 0) begin : g_head
            assign prev_after = 1'b0;
            assign prev_key   = i_in_req.key;
            assign prev_tag   = i_in_req.tag;
        end else begin : g_body
            assign prev_after = after[g-1];
            assign prev_key   = ckey[g-1];
            assign prev_tag   = ctag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_key = ckey[g];
            assign next_tag = ctag[g];
        end else begin : g_inner
            assign next_key = ckey[g+1];
            assign next_tag = ctag[g+1];
        end

        ssq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occupied   (IDX < r_count),
            .i_prev_after (prev_after),
            .i_prev_key   (prev_key),
            .i_prev_tag   (prev_tag),
            .i_next_key   (next_key),
            .i_next_tag   (next_tag),
            .o_after      (after[g]),
            .o_key        (ckey[g]),
            .o_tag        (ctag[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_served_valid <= ctrl.rem;
            r_served_key   <= ctrl.rem ? ckey[0] : '0;
            r_served_tag   <= ctrl.rem ? ctag[0] : '0;
            r_status       <= n_status;
        end
    end

    // head comes straight from the first cell, which holds while the result waits
    always_comb begin
        o_out_req.served_valid = r_served_valid;
        o_out_req.served_key   = r_served_key;
        o_out_req.served_tag   = r_served_tag;
        o_out_req.head_valid   = !empty;
        o_out_req.head_key     = empty ? '0 : ckey[0];
        o_out_req.head_tag     = empty ? '0 : ctag[0];
        o_out_req.fill_count   = ssq_pkg::FILL_W'(r_count);
        o_out_req.status       = r_status;
    end

    assign o_out_valid = r_out_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ins |=> (r_count == $past(r_count) + 1'b1) && o_out_valid)
        else $error("insert did not grow the queue");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && empty && (i_in_req.operation == ssq_pkg::OP_REMOVE)) |=>
        (o_out_req.status == ssq_pkg::ST_EMPTY) && !o_out_req.served_valid
        && o_out_valid)
        else $error("remove on empty queue misreported");

    a_served_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.served_valid) |-> (o_out_req.status == ssq_pkg::ST_OK))
        else $error("served entry with error status");

endmodule

`default_nettype wire
